### src/cooperative_task_scheduler_defines.svh
// Assertion macros for the cooperative task scheduler.
// No dependencies; included by the top level.
`ifndef COOPERATIVE_TASK_SCHEDULER_DEFINES_SVH
`define COOPERATIVE_TASK_SCHEDULER_DEFINES_SVH
// Implication checked every clock, disabled in reset.
`define CTS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication.
`define CTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

### src/cts_pkg.sv
// Shared types and constants for the cooperative task scheduler.
// No dependencies.
package cts_pkg;
  localparam int NUM_SLOTS_DEF = 8;
  localparam int MAX_OUT = 8;

  typedef enum logic [2:0] {
    KIND_TICK     = 3'd0,
    KIND_ADD      = 3'd1,
    KIND_DEL      = 3'd2,
    KIND_DEL_ALL  = 3'd3,
    KIND_DISPATCH = 3'd4
  } kind_t;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_BAD     = 2'd2;
  localparam logic [1:0] ST_NOREADY = 2'd3;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] task_handle;
    logic [7:0]  first_delay;
    logic [15:0] period;
    logic [3:0]  slot;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  slot_out;
    logic [15:0] handle_out;
    logic [1:0]  status;
    logic        last;
  } res_t;
endpackage

### src/cts_if.sv
// Valid/ready channel interfaces for requests and results.
// Depends on cts_pkg.
interface cts_cmd_if;
  logic              valid;
  logic              ready;
  cts_pkg::cmd_t     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cts_res_if;
  logic              valid;
  logic              ready;
  cts_pkg::res_t     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### src/cooperative_task_scheduler.sv
// Cooperative task scheduler top level: front queue plus slot-table back end.
// Depends on cts_pkg, cts_if, cts_front, cts_back and the defines header.
//
// Usage: requests arrive on cmd (valid/ready, payload kind, task_handle,
// first_delay, period, slot); results leave on res (slot_out, handle_out,
// status, last). Each request yields one or more results; last marks the
// final one. Kinds 5 to 7 are dropped with no result.
// Add, delete and delete-all give their result from the result register
// once the back end pops them from the queue. Tick and dispatch walk the
// table one slot per cycle, set by the single table sequencer in the back
// end; dispatch gives its final result from a separate output state after
// the walk, and its walk pauses while res stalls.
// A two-entry request queue lets the front keep accepting while the back
// end is busy; cmd.ready drops only when that queue is full.
// Reset (rst, synchronous): empties the queue, frees every slot and clears
// every count. A stalled receiver holds the result register and pauses the
// dispatch walk; nothing is lost.
`include "cooperative_task_scheduler_defines.svh"
module cooperative_task_scheduler #(
  parameter int NUM_SLOTS = cts_pkg::NUM_SLOTS_DEF
) (
  input logic       clk,
  input logic       rst,
  cts_cmd_if.sink   cmd,
  cts_res_if.source res
);
  import cts_pkg::*;

  cmd_t q_data;
  logic q_valid;
  logic q_pop;

  cts_front u_front (
    .clk, .rst, .cmd,
    .q_data, .q_valid, .q_pop
  );

  cts_back #(.NUM_SLOTS(NUM_SLOTS)) u_back (
    .clk, .rst,
    .q_data, .q_valid, .q_pop,
    .res
  );

  // A stalled result must hold its value.
  `CTS_ASSERT_NEXT(a_res_hold, res.valid && !res.ready, res.valid && $stable(res.data), "result changed while stalled")
  // Queue never pops when empty.
  `CTS_ASSERT_IMPL(a_pop_valid, q_pop, q_valid, "pop from empty queue")
  // Non-final results always report ok.
  `CTS_ASSERT_IMPL(a_mid_ok, res.valid && !res.data.last, res.data.status == ST_OK, "bad status mid-dispatch")
endmodule

### src/cts_front.sv
// Front end: accepts requests, drops unknown kinds, queues the rest.
// Depends on cts_pkg.
module cts_front (
  input  logic          clk,
  input  logic          rst,
  cts_cmd_if.sink       cmd,
  output cts_pkg::cmd_t q_data,
  output logic          q_valid,
  input  logic          q_pop
);
  import cts_pkg::*;

  // two-entry queue
  cmd_t       mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       push, known;

  assign known = (cmd.data.kind <= KIND_DISPATCH);
  assign cmd.ready = (count != 2'd2);
  assign push = cmd.valid && cmd.ready && known;
  assign q_valid = (count != 2'd0);
  assign q_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
    if (push) mem[wr_ptr] <= cmd.data;
  end
endmodule

### src/cts_back.sv
// Back end: slot table and the per-slot sequencer for tick and dispatch.
// Depends on cts_pkg.
module cts_back #(
  parameter int NUM_SLOTS = cts_pkg::NUM_SLOTS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  cts_pkg::cmd_t q_data,
  input  logic          q_valid,
  output logic          q_pop,
  cts_res_if.source     res
);
  import cts_pkg::*;

  localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CW = $clog2(NUM_SLOTS + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  state_t         state;
  logic [NUM_SLOTS-1:0] valid;
  logic [15:0]    handle  [NUM_SLOTS];
  logic [15:0]    delay   [NUM_SLOTS];
  logic [15:0]    period  [NUM_SLOTS];
  logic [7:0]     pending [NUM_SLOTS];
  logic [IW-1:0]  idx;
  logic [CW-1:0]  nout;
  logic           is_tick;
  logic           last_slot;
  // one dispatched result held until the next one (or the end) shows last
  res_t           hold;
  logic           hold_v;

  logic [IW-1:0]  free_idx;
  logic           free_found;
  logic           out_free;

  always_comb begin
    free_idx = '0;
    free_found = 1'b0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_idx = IW'(i);
        free_found = 1'b1;
      end
    end
  end

  assign out_free = !res.valid || res.ready;
  assign last_slot = (CW'(idx) == CW'(NUM_SLOTS - 1));
  assign q_pop = (state == S_IDLE) && q_valid && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= '0;
      res.valid <= 1'b0;
      hold_v <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        pending[i] <= '0;
        delay[i] <= '0;
        period[i] <= '0;
        handle[i] <= '0;
      end
    end else begin
      if (res.valid && res.ready) res.valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_pop) begin
            res.data <= '{slot_out: 3'd0, handle_out: 16'd0, status: ST_OK, last: 1'b1};
            unique case (q_data.kind)
              KIND_TICK, KIND_DISPATCH: begin
                idx <= '0;
                nout <= '0;
                hold_v <= 1'b0;
                is_tick <= (q_data.kind == KIND_TICK);
                state <= S_SCAN;
              end
              KIND_ADD: begin
                res.valid <= 1'b1;
                if (free_found) begin
                  valid[free_idx] <= 1'b1;
                  handle[free_idx] <= q_data.task_handle;
                  delay[free_idx] <= {8'd0, q_data.first_delay};
                  period[free_idx] <= q_data.period;
                  pending[free_idx] <= '0;
                  res.data.slot_out <= 3'(free_idx);
                end else begin
                  res.data.status <= ST_FULL;
                end
              end
              KIND_DEL: begin
                res.valid <= 1'b1;
                if (32'(q_data.slot) >= NUM_SLOTS) begin
                  res.data.status <= ST_BAD;
                end else begin
                  valid[IW'(q_data.slot)] <= 1'b0;
                  handle[IW'(q_data.slot)] <= '0;
                  delay[IW'(q_data.slot)] <= '0;
                  period[IW'(q_data.slot)] <= '0;
                  pending[IW'(q_data.slot)] <= '0;
                  res.data.slot_out <= 3'(q_data.slot);
                end
              end
              default: begin
                res.valid <= 1'b1;
                valid <= '0;
                for (int i = 0; i < NUM_SLOTS; i++) begin
                  handle[i] <= '0;
                  delay[i] <= '0;
                  period[i] <= '0;
                  pending[i] <= '0;
                end
              end
            endcase
          end
        end
        S_SCAN: begin
          // one slot per cycle; dispatch steps only while the result register is free
          if (is_tick) begin
            if (valid[idx]) begin
              if (delay[idx] == '0) begin
                if (pending[idx] != 8'hFF) pending[idx] <= pending[idx] + 8'd1;
                if (period[idx] != '0) delay[idx] <= period[idx];
              end else begin
                delay[idx] <= delay[idx] - 16'd1;
              end
            end
            if (last_slot) begin
              res.valid <= 1'b1;
              state <= S_IDLE;
            end else begin
              idx <= idx + 1'b1;
            end
          end else if (out_free) begin
            if (valid[idx] && pending[idx] != '0 && nout < CW'(MAX_OUT)) begin
              if (hold_v) begin
                res.valid <= 1'b1;
                res.data <= hold;
              end
              hold <= '{slot_out: 3'(idx), handle_out: handle[idx], status: ST_OK,
                        last: 1'b0};
              hold_v <= 1'b1;
              nout <= nout + 1'b1;
              if (period[idx] == '0) begin
                valid[idx] <= 1'b0;
                handle[idx] <= '0;
                delay[idx] <= '0;
                pending[idx] <= '0;
              end else begin
                pending[idx] <= pending[idx] - 8'd1;
              end
            end
            if (last_slot) state <= S_OUT;
            else idx <= idx + 1'b1;
          end
        end
        S_OUT: begin
          if (out_free) begin
            res.valid <= 1'b1;
            if (hold_v) res.data <= '{slot_out: hold.slot_out, handle_out: hold.handle_out,
                                      status: ST_OK, last: 1'b1};
            else res.data <= '{slot_out: 3'd0, handle_out: 16'd0, status: ST_NOREADY,
                               last: 1'b1};
            hold_v <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

### test/cts_checker.sv
`timescale 1ns / 100ps
// Checker for the cooperative task scheduler: predicts results from accepted requests.
// Depends on cts_pkg and cts_if; instantiated beside the block by the testbench top.
module cts_checker (
  input  logic      clk,
  input  logic      rst,
  cts_cmd_if.sink   cmd,
  cts_res_if.sink   res,
  output int        errors,
  output int        pending_results
);
  import cts_pkg::*;

  localparam int SLOTS = NUM_SLOTS_DEF;

  logic        tbl_valid   [SLOTS];
  logic [15:0] tbl_handle  [SLOTS];
  logic [15:0] tbl_delay   [SLOTS];
  logic [15:0] tbl_period  [SLOTS];
  logic [7:0]  tbl_runs    [SLOTS];

  res_t awaited_q[$];

  assign pending_results = awaited_q.size();

  function automatic res_t mk(logic [2:0] s, logic [15:0] h, logic [1:0] st, logic l);
    res_t r;
    r.slot_out = s;
    r.handle_out = h;
    r.status = st;
    r.last = l;
    return r;
  endfunction

  function automatic void free_slot(int i);
    tbl_valid[i] = 1'b0;
    tbl_handle[i] = '0;
    tbl_delay[i] = '0;
    tbl_period[i] = '0;
    tbl_runs[i] = '0;
  endfunction

  task automatic schedule_request(cmd_t c);
    int n;
    bit placed;
    n = 0;
    placed = 0;
    case (c.kind)
      KIND_TICK: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!tbl_valid[i]) continue;
          if (tbl_delay[i] == 0) begin
            if (tbl_runs[i] != 8'hFF) tbl_runs[i]++;
            if (tbl_period[i] != 0) tbl_delay[i] = tbl_period[i];
          end else begin
            tbl_delay[i]--;
          end
        end
        awaited_q.push_back(mk('0, '0, ST_OK, 1'b1));
      end
      KIND_ADD: begin
        for (int i = 0; i < SLOTS && !placed; i++) begin
          if (!tbl_valid[i]) begin
            tbl_valid[i] = 1'b1;
            tbl_handle[i] = c.task_handle;
            tbl_delay[i] = {8'h00, c.first_delay};
            tbl_period[i] = c.period;
            tbl_runs[i] = '0;
            awaited_q.push_back(mk(i[2:0], '0, ST_OK, 1'b1));
            placed = 1;
          end
        end
        if (!placed) awaited_q.push_back(mk('0, '0, ST_FULL, 1'b1));
      end
      KIND_DEL: begin
        if (c.slot >= SLOTS) begin
          awaited_q.push_back(mk('0, '0, ST_BAD, 1'b1));
        end else begin
          free_slot(c.slot);
          awaited_q.push_back(mk(c.slot[2:0], '0, ST_OK, 1'b1));
        end
      end
      KIND_DEL_ALL: begin
        for (int i = 0; i < SLOTS; i++) free_slot(i);
        awaited_q.push_back(mk('0, '0, ST_OK, 1'b1));
      end
      KIND_DISPATCH: begin
        for (int i = 0; i < SLOTS && n < MAX_OUT; i++) begin
          if (!tbl_valid[i] || tbl_runs[i] == 0) continue;
          awaited_q.push_back(mk(i[2:0], tbl_handle[i], ST_OK, 1'b0));
          n++;
          tbl_runs[i]--;
          if (tbl_period[i] == 0) free_slot(i);
        end
        if (n == 0) awaited_q.push_back(mk('0, '0, ST_NOREADY, 1'b1));
        else awaited_q[$].last = 1'b1;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    res_t want;
    int   errs_now;
    errs_now = 0;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) free_slot(i);
      awaited_q.delete();
      errors <= 0;
    end else begin
      if (cmd.valid && cmd.ready) schedule_request(cmd.data);
      if (res.valid && res.ready) begin
        if (awaited_q.size() == 0) begin
          $error("unexpected result %p", res.data);
          errs_now++;
        end else begin
          want = awaited_q.pop_front();
          if (res.data.slot_out !== want.slot_out) begin
            $error("slot_out expected %0d actual %0d", want.slot_out, res.data.slot_out);
            errs_now++;
          end
          if (res.data.handle_out !== want.handle_out) begin
            $error("handle_out expected %h actual %h", want.handle_out, res.data.handle_out);
            errs_now++;
          end
          if (res.data.status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, res.data.status);
            errs_now++;
          end
          if (res.data.last !== want.last) begin
            $error("last expected %0d actual %0d", want.last, res.data.last);
            errs_now++;
          end
        end
      end
      errors <= errors + errs_now;
    end
  end
endmodule

### test/tb_cooperative_task_scheduler.sv
`timescale 1ns / 100ps
// Testbench top for the cooperative task scheduler: stimulus, receiver stalls, verdict.
// Depends on cts_pkg, cts_if, the block and cts_checker.
module tb_cooperative_task_scheduler;
  import cts_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   errors;
  int   pending_results;
  bit   hold_off = 0;     // long receiver stall to back up the request queue
  bit   flood = 0;        // sender offers back to back during the stall

  cts_cmd_if cmd ();
  cts_res_if res ();

  cooperative_task_scheduler uut (.clk(clk), .rst(rst), .cmd(cmd), .res(res));
  cts_checker chk (.clk(clk), .rst(rst), .cmd(cmd), .res(res),
    .errors(errors), .pending_results(pending_results));

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver: stall pattern of its own; each clock picks free flow, random or heavy stalls.
  always @(posedge clk) begin
    int mode;
    mode = ($urandom_range(0, 199) < 100) ? 0 : $urandom_range(1, 2);
    if (hold_off) res.ready <= 1'b0;
    else case (mode)
      0: res.ready <= 1'b1;
      1: res.ready <= $urandom_range(0, 3) != 0;
      default: res.ready <= $urandom_range(0, 3) == 0;
    endcase
  end

  // Send one request and hold it until cmd.ready accepts it.
  task automatic send_request(cmd_t c);
    cmd.valid <= 1'b1;
    cmd.data <= c;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
  endtask

  task automatic drop_valid_maybe(ref int burst_left);
    if (burst_left > 0 || flood) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 12);
    cmd.valid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk);
  endtask

  function automatic cmd_t make_cmd(logic [2:0] k, logic [15:0] h, logic [7:0] d,
                                    logic [15:0] p, logic [3:0] s);
    cmd_t c;
    c.kind = k;
    c.task_handle = h;
    c.first_delay = d;
    c.period = p;
    c.slot = s;
    return c;
  endfunction

  // Mostly adds, ticks and dispatches with small delays so tasks actually come due.
  function automatic cmd_t random_cmd();
    int pick;
    logic [15:0] h;
    logic [7:0] d;
    logic [15:0] p;
    logic [3:0] s;
    pick = $urandom_range(0, 99);
    h = 16'($urandom);
    s = 4'($urandom);
    d = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
    p = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
    if (pick < 30) return make_cmd(KIND_TICK, h, d, p, s);
    if (pick < 55) return make_cmd(KIND_ADD, h, d, p, s);
    if (pick < 80) return make_cmd(KIND_DISPATCH, h, d, p, s);
    if (pick < 92) return make_cmd(KIND_DEL, h, d, p, s);
    if (pick < 96) return make_cmd(KIND_DEL_ALL, h, d, p, s);
    return make_cmd(3'($urandom_range(5, 7)), h, d, p, s);
  endfunction

  initial begin
    int burst_left;
    burst_left = 0;
    cmd.valid <= 1'b0;
    cmd.data <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty dispatch, fill past full, extremes, zero handle, bad slots.
    send_request(make_cmd(KIND_DISPATCH, '0, '0, '0, '0));
    send_request(make_cmd(KIND_ADD, 16'h0000, 8'h00, 16'h0000, '0));
    send_request(make_cmd(KIND_ADD, 16'hFFFF, 8'hFF, 16'hFFFF, 4'hF));
    for (int i = 0; i < 6; i++)
      send_request(make_cmd(KIND_ADD, 16'(16'h1000 + i), 8'(i % 2), 16'(i % 3), '0));
    send_request(make_cmd(KIND_ADD, 16'hABCD, 8'd1, 16'd1, '0));
    send_request(make_cmd(KIND_TICK, '0, '0, '0, '0));
    send_request(make_cmd(KIND_TICK, 16'hFFFF, 8'hFF, 16'hFFFF, 4'hF));
    send_request(make_cmd(KIND_DISPATCH, '0, '0, '0, '0));
    send_request(make_cmd(KIND_DEL, '0, '0, '0, 4'd7));
    send_request(make_cmd(KIND_DEL, '0, '0, '0, 4'd7));
    send_request(make_cmd(KIND_DEL, '0, '0, '0, 4'd8));
    send_request(make_cmd(KIND_DEL, '0, '0, '0, 4'hF));
    send_request(make_cmd(3'd5, 16'hFFFF, 8'hFF, 16'hFFFF, 4'hF));
    send_request(make_cmd(3'd7, '0, '0, '0, '0));
    send_request(make_cmd(KIND_DISPATCH, '0, '0, '0, '0));
    send_request(make_cmd(KIND_DEL_ALL, '0, '0, '0, '0));
    // Run count build-up: one task due every other tick, 260 ticks undispatched.
    send_request(make_cmd(KIND_ADD, 16'h5A5A, 8'd0, 16'd1, '0));
    for (int i = 0; i < 260; i++) begin
      send_request(make_cmd(KIND_TICK, '0, '0, '0, '0));
      drop_valid_maybe(burst_left);
    end
    send_request(make_cmd(KIND_DISPATCH, '0, '0, '0, '0));
    send_request(make_cmd(KIND_DEL_ALL, '0, '0, '0, '0));

    // Pressure: receiver stalls long while the sender keeps offering.
    hold_off = 1;
    flood = 1;
    fork
      begin
        repeat (60) @(posedge clk);
        hold_off = 0;
      end
      for (int i = 0; i < 12; i++) send_request(random_cmd());
    join
    flood = 0;

    for (int i = 0; i < 40; i++) begin
      send_request(random_cmd());
      drop_valid_maybe(burst_left);
    end
    cmd.valid <= 1'b0;

    while (pending_results != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) $display("cooperative_task_scheduler verification clean");
    else $display("cooperative_task_scheduler verification failed");
    $finish;
  end

  initial begin
    #4000000;
    $display("cooperative_task_scheduler verification failed");
    $finish;
  end
endmodule
